// File: src/dps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types, widths and constants of the density profile sampler.
// ----------------------------------------------------------------------------
package dps_pkg;

   localparam int HEIGHT_W    = 18;
   localparam int LEN_W       = 18;
   localparam int PEAK_W      = 32;
   localparam int TOTAL_W     = 33;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // exponent datapath: Q1.31 accumulator, Q5.16 argument
   localparam int ACC_W     = 32;
   localparam int ARG_FRAC  = 16;
   localparam int XQ_W      = 21;               // argument bits below the cutoff of 32
   localparam int HLOW_W    = XQ_W - ARG_FRAC;  // height bits that feed the first divide
   localparam int DEXP_SH   = ARG_FRAC + 2;     // double exponential cutoff at 4
   localparam int UQ_W      = 22;               // reciprocal quotient bits
   localparam int RECIP_SH  = 47;               // 1.0 in Q1.31 times 1.0 in Q.16
   localparam logic [ACC_W-1:0] ONE_Q31 = 32'h8000_0000;

   // stages inside one mode lane: front end, four long sections, factor, product
   localparam int CORE_STAGES = XQ_W + XQ_W + UQ_W + XQ_W;
   localparam int MODE_LAT    = CORE_STAGES + 3;

   typedef enum logic [1:0] {
      SHAPE_EXP  = 2'd0,
      SHAPE_DEXP = 2'd1,
      SHAPE_TENT = 2'd2,
      SHAPE_OFF  = 2'd3
   } shape_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_M0_SHAPE = 3'd0,
      REG_M0_PEAK  = 3'd1,
      REG_M0_LEN_A = 3'd2,
      REG_M0_LEN_B = 3'd3,
      REG_M1_SHAPE = 3'd4,
      REG_M1_PEAK  = 3'd5,
      REG_M1_LEN_A = 3'd6,
      REG_M1_LEN_B = 3'd7
   } reg_index_type;

   typedef struct packed {
      shape_type          shape;
      logic [PEAK_W-1:0]  peak;
      logic [LEN_W-1:0]   len_a;
      logic [LEN_W-1:0]   len_b;
   } mode_cfg_type;

   // exp(-2^(idx-16)) in Q1.31
   function automatic logic [ACC_W-1:0] neg_exp_coef(input int unsigned idx);
      logic [ACC_W-1:0] c;
      case (idx)
         0:       c = 32'd2147450880;
         1:       c = 32'd2147418113;
         2:       c = 32'd2147352580;
         3:       c = 32'd2147221520;
         4:       c = 32'd2146959424;
         5:       c = 32'd2146435328;
         6:       c = 32'd2145387520;
         7:       c = 32'd2143293437;
         8:       c = 32'd2139111403;
         9:       c = 32'd2130771798;
         10:      c = 32'd2114190000;
         11:      c = 32'd2081412522;
         12:      c = 32'd2017374191;
         13:      c = 32'd1895147668;
         14:      c = 32'd1672461947;
         15:      c = 32'd1302514674;
         16:      c = 32'd790015084;
         17:      c = 32'd290630308;
         18:      c = 32'd39332535;
         19:      c = 32'd720400;
         20:      c = 32'd242;
         default: c = 32'd0;
      endcase
      return c;
   endfunction

endpackage

// File: src/dps_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_div_step
// One registered restoring-divide step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module dps_div_step
   import dps_pkg::*;
#(
   parameter int DW = 18,
   parameter int QW = 21,
   parameter int SW = 1
)
(
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] rem_i,
   input  logic          bit_i,
   input  logic [DW-1:0] div_i,
   input  logic [QW-1:0] q_i,
   input  logic [SW-1:0] side_i,
   output logic [DW-1:0] rem_o,
   output logic [QW-1:0] q_o,
   output logic [SW-1:0] side_o
);

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;
   logic [DW-1:0] rem_in;
   logic [QW-1:0] q_in;
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] q_ff;
   logic [SW-1:0] side_ff;

   always_comb begin
      trial  = {rem_i, bit_i};
      diff   = trial - {1'b0, div_i};
      ge     = (trial >= {1'b0, div_i});
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_in   = {q_i[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         side_ff <= side_i;
      end
   end

   assign rem_o  = rem_ff;
   assign q_o    = q_ff;
   assign side_o = side_ff;

endmodule

// File: src/dps_exp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_exp_step
// One registered exponent step: multiply by exp(-2^(IDX-16)) if the bit is set.
// ----------------------------------------------------------------------------
module dps_exp_step
   import dps_pkg::*;
#(
   parameter int IDX = 0,
   parameter int SW  = 1
)
(
   input  logic             clock,
   input  logic             en,
   input  logic [ACC_W-1:0] acc_i,
   input  logic             xbit_i,
   input  logic [SW-1:0]    side_i,
   output logic [ACC_W-1:0] acc_o,
   output logic [SW-1:0]    side_o
);

   localparam logic [ACC_W-1:0] COEF = neg_exp_coef(IDX);

   logic [2*ACC_W-1:0] prod;
   logic [ACC_W-1:0]   acc_in;
   logic [ACC_W-1:0]   acc_ff;
   logic [SW-1:0]      side_ff;

   // round to nearest in Q1.31
   always_comb begin
      prod   = (2*ACC_W)'(acc_i) * (2*ACC_W)'(COEF) + ((2*ACC_W)'(1) << (ACC_W-2));
      acc_in = xbit_i ? prod[ACC_W-1 +: ACC_W] : acc_i;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff  <= acc_in;
         side_ff <= side_i;
      end
   end

   assign acc_o  = acc_ff;
   assign side_o = side_ff;

endmodule

// File: src/dps_mode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_mode
// One density mode lane: divide, exponent, reciprocal, exponent, factor, product; tent divide alongside.
// ----------------------------------------------------------------------------
module dps_mode
   import dps_pkg::*;
#(
   parameter int FACTOR_BITS = 16
)
(
   input  logic                clock,
   input  logic                en,
   input  mode_cfg_type        cfg,
   input  logic [HEIGHT_W-1:0] height,
   output logic [PEAK_W-1:0]   density
);

   localparam int FW       = FACTOR_BITS + 1;
   localparam int TENT_DLY = CORE_STAGES - FW;
   localparam int AS_W     = HLOW_W + 1;
   localparam int BS_W     = XQ_W + 2;
   localparam int CS_W     = ACC_W + 1;
   localparam int DS_W     = ACC_W + 1 + XQ_W;

   logic [LEN_W-1:0] a_eff;
   logic [LEN_W-1:0] w_eff;
   logic [LEN_W-1:0] span;
   logic [LEN_W-1:0] t_n;

   // front end registers
   logic [LEN_W-1:0] a_rem0_in, a_rem0_ff;
   logic [AS_W-1:0]  a_side0_in, a_side0_ff;
   logic [LEN_W-1:0] t_rem0_in, t_rem0_ff;
   logic             t_n0_in, t_n0_ff;
   logic             t_z_in, t_z_ff;

   assign a_eff = (cfg.len_a == '0) ? LEN_W'(1) : cfg.len_a;
   assign w_eff = (cfg.len_b == '0) ? LEN_W'(1) : cfg.len_b;

   always_comb begin
      // h / H saturates when h >= 32 H
      a_rem0_in  = LEN_W'(height[HEIGHT_W-1:HLOW_W]);
      a_side0_in = {(LEN_W'(height[HEIGHT_W-1:HLOW_W]) >= a_eff), height[HLOW_W-1:0]};
      span       = (height >= cfg.len_a) ? (height - cfg.len_a) : (cfg.len_a - height);
      t_z_in     = (span >= w_eff);
      t_n        = w_eff - span;
      t_rem0_in  = t_n >> 1;
      t_n0_in    = t_n[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_rem0_ff  <= a_rem0_in;
         a_side0_ff <= a_side0_in;
         t_rem0_ff  <= t_rem0_in;
         t_n0_ff    <= t_n0_in;
         t_z_ff     <= t_z_in;
      end
   end

   // section A: x = h * 2^16 / H
   logic [LEN_W-1:0] a_rem  [0:XQ_W];
   logic [XQ_W-1:0]  a_q    [0:XQ_W];
   logic [AS_W-1:0]  a_side [0:XQ_W];

   assign a_rem[0]  = a_rem0_ff;
   assign a_q[0]    = '0;
   assign a_side[0] = a_side0_ff;

   for (genvar k = 0; k < XQ_W; k++) begin : g_div_x
      logic bit_k;
      if (k < HLOW_W) begin : g_low
         assign bit_k = a_side[k][HLOW_W-1-k];
      end else begin : g_zero
         assign bit_k = 1'b0;
      end
      dps_div_step #(.DW(LEN_W), .QW(XQ_W), .SW(AS_W)) u_step (
         .clock  (clock),
         .en     (en),
         .rem_i  (a_rem[k]),
         .bit_i  (bit_k),
         .div_i  (a_eff),
         .q_i    (a_q[k]),
         .side_i (a_side[k]),
         .rem_o  (a_rem[k+1]),
         .q_o    (a_q[k+1]),
         .side_o (a_side[k+1])
      );
   end

   // section B: exp(-x)
   logic [ACC_W-1:0] b_acc  [0:XQ_W];
   logic [BS_W-1:0]  b_side [0:XQ_W];
   logic             ovf1;
   logic             dz0;

   assign ovf1      = a_side[XQ_W][HLOW_W];
   assign dz0       = ovf1 | (|a_q[XQ_W][XQ_W-1:DEXP_SH]);
   assign b_acc[0]  = ONE_Q31;
   assign b_side[0] = {dz0, ovf1, a_q[XQ_W]};

   for (genvar k = 0; k < XQ_W; k++) begin : g_exp_x
      dps_exp_step #(.IDX(k), .SW(BS_W)) u_step (
         .clock  (clock),
         .en     (en),
         .acc_i  (b_acc[k]),
         .xbit_i (b_side[k][k]),
         .side_i (b_side[k]),
         .acc_o  (b_acc[k+1]),
         .side_o (b_side[k+1])
      );
   end

   // section C: exp(x) = (2^47 + d/2) / d
   logic [ACC_W-1:0] e1;
   logic [ACC_W-1:0] c_rem  [0:UQ_W];
   logic [UQ_W-1:0]  c_q    [0:UQ_W];
   logic [CS_W-1:0]  c_side [0:UQ_W];

   assign e1        = b_side[XQ_W][XQ_W] ? '0 : b_acc[XQ_W];
   assign c_rem[0]  = (ACC_W'(1) << (RECIP_SH - UQ_W)) + (e1 >> (UQ_W + 1));
   assign c_q[0]    = '0;
   assign c_side[0] = {b_side[XQ_W][XQ_W+1], e1};

   for (genvar k = 0; k < UQ_W; k++) begin : g_div_r
      dps_div_step #(.DW(ACC_W), .QW(UQ_W), .SW(CS_W)) u_step (
         .clock  (clock),
         .en     (en),
         .rem_i  (c_rem[k]),
         .bit_i  (c_side[k][UQ_W-k]),
         .div_i  (c_side[k][ACC_W-1:0]),
         .q_i    (c_q[k]),
         .side_i (c_side[k]),
         .rem_o  (c_rem[k+1]),
         .q_o    (c_q[k+1]),
         .side_o (c_side[k+1])
      );
   end

   // section D: exp(-(exp(x) - 1))
   logic [UQ_W-1:0]  uq;
   logic             z2;
   logic [ACC_W-1:0] d_acc  [0:XQ_W];
   logic [DS_W-1:0]  d_side [0:XQ_W];

   assign uq        = c_q[UQ_W] - (UQ_W'(1) << ARG_FRAC);
   assign z2        = c_side[UQ_W][ACC_W] | uq[UQ_W-1];
   assign d_acc[0]  = ONE_Q31;
   assign d_side[0] = {c_side[UQ_W][ACC_W-1:0], z2, uq[XQ_W-1:0]};

   for (genvar k = 0; k < XQ_W; k++) begin : g_exp_u
      dps_exp_step #(.IDX(k), .SW(DS_W)) u_step (
         .clock  (clock),
         .en     (en),
         .acc_i  (d_acc[k]),
         .xbit_i (d_side[k][k]),
         .side_i (d_side[k]),
         .acc_o  (d_acc[k+1]),
         .side_o (d_side[k+1])
      );
   end

   // tent: (W - span) * 2^F / W, then delayed to line up with the exponent path
   logic [LEN_W-1:0] t_rem  [0:FW];
   logic [FW-1:0]    t_q    [0:FW];
   logic             t_side [0:FW];
   logic [FW-1:0]    td_in;
   logic [FW-1:0]    td_ff  [0:TENT_DLY-1];

   assign t_rem[0]  = t_rem0_ff;
   assign t_q[0]    = '0;
   assign t_side[0] = t_z_ff;

   for (genvar k = 0; k < FW; k++) begin : g_div_t
      logic bit_k;
      if (k == 0) begin : g_first
         assign bit_k = t_n0_ff;
      end else begin : g_zero
         assign bit_k = 1'b0;
      end
      dps_div_step #(.DW(LEN_W), .QW(FW), .SW(1)) u_step (
         .clock  (clock),
         .en     (en),
         .rem_i  (t_rem[k]),
         .bit_i  (bit_k),
         .div_i  (w_eff),
         .q_i    (t_q[k]),
         .side_i (t_side[k]),
         .rem_o  (t_rem[k+1]),
         .q_o    (t_q[k+1]),
         .side_o (t_side[k+1])
      );
   end

   assign td_in = t_side[FW] ? '0 : t_q[FW];

   always_ff @(posedge clock) begin
      if (en) begin
         td_ff[0] <= td_in;
         for (int i = 1; i < TENT_DLY; i++) begin
            td_ff[i] <= td_ff[i-1];
         end
      end
   end

   // factor select and Q1.31 to Q1.F rounding
   logic [ACC_W-1:0] v;
   logic [ACC_W:0]   v_rnd;
   logic [FW-1:0]    fexp;
   logic [FW-1:0]    fac_in, fac_ff;

   always_comb begin
      case (cfg.shape)
         SHAPE_EXP:  v = d_side[XQ_W][XQ_W+1 +: ACC_W];
         SHAPE_DEXP: v = d_side[XQ_W][XQ_W] ? '0 : d_acc[XQ_W];
         default:    v = '0;
      endcase
      v_rnd = {1'b0, v} + ((ACC_W+1)'(1) << (ACC_W - 2 - FACTOR_BITS));
      fexp  = FW'(v_rnd >> (ACC_W - 1 - FACTOR_BITS));
      case (cfg.shape)
         SHAPE_TENT: fac_in = td_ff[TENT_DLY-1];
         SHAPE_OFF:  fac_in = '0;
         default:    fac_in = fexp;
      endcase
   end

   // density = peak * factor >> F
   logic [PEAK_W+FW-1:0] prod;
   logic [PEAK_W-1:0]    dens_in, dens_ff;

   assign prod    = (PEAK_W+FW)'(cfg.peak) * (PEAK_W+FW)'(fac_ff);
   assign dens_in = prod[FACTOR_BITS +: PEAK_W];

   always_ff @(posedge clock) begin
      if (en) begin
         fac_ff  <= fac_in;
         dens_ff <= dens_in;
      end
   end

   assign density = dens_ff;

endmodule

// File: src/density_profile_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// density_profile_sampler
// Two-mode atmosphere density at one altitude, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one altitude in meters per item; rsp_* returns the summed
//    density of both modes for that item, in order.
//  - csr_* writes the eight mode registers (shape, peak, len_a, len_b per
//    mode). Write them only while no item is in flight.
//  - From req accept, the accepting edge loads the input register, then 88
//    lane stages (front end, 21-bit divide, 21 exponent multiplies, 22-bit
//    reciprocal divide, 21 exponent multiplies, factor, product) and the
//    output register follow before rsp_tvalid.
//  - Throughput is one item per cycle while the output is not stalled; each
//    divide stage yields one quotient bit and each exponent stage one 32x32
//    multiply, so every stage is free for a new item on the next clock.
//  - When the consumer stalls, the whole pipeline holds (req_tready low) and
//    restarts with nothing lost or repeated.
//  - Reset empties the pipeline and returns both modes to disabled, peak 0,
//    lengths 1.
// ----------------------------------------------------------------------------
module density_profile_sampler
   import dps_pkg::*;
#(
   parameter int FACTOR_BITS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   // altitude in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [17:0] height_m
   // density out
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [32:0] total_density
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------------------------------------------------------- config
   mode_cfg_type m0_cfg_in, m0_cfg_ff;
   mode_cfg_type m1_cfg_in, m1_cfg_ff;

   always_comb begin
      m0_cfg_in = m0_cfg_ff;
      m1_cfg_in = m1_cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_M0_SHAPE: m0_cfg_in.shape = shape_type'(csr_wdata[1:0]);
            REG_M0_PEAK:  m0_cfg_in.peak  = csr_wdata[PEAK_W-1:0];
            REG_M0_LEN_A: m0_cfg_in.len_a = csr_wdata[LEN_W-1:0];
            REG_M0_LEN_B: m0_cfg_in.len_b = csr_wdata[LEN_W-1:0];
            REG_M1_SHAPE: m1_cfg_in.shape = shape_type'(csr_wdata[1:0]);
            REG_M1_PEAK:  m1_cfg_in.peak  = csr_wdata[PEAK_W-1:0];
            REG_M1_LEN_A: m1_cfg_in.len_a = csr_wdata[LEN_W-1:0];
            REG_M1_LEN_B: m1_cfg_in.len_b = csr_wdata[LEN_W-1:0];
            default:      m0_cfg_in = m0_cfg_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline control
   // one advance enable for every stage; a held result holds them all
   logic                  adv;
   logic                  vin_ff;
   logic [MODE_LAT-1:0]   vld_ff;
   logic                  rsp_tvalid_ff;
   logic [HEIGHT_W-1:0]   h_ff;
   logic [TOTAL_W-1:0]    total_in, total_ff;
   logic [PEAK_W-1:0]     dens0;
   logic [PEAK_W-1:0]     dens1;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         m0_cfg_ff     <= '{shape: SHAPE_OFF, peak: '0, len_a: LEN_W'(1), len_b: LEN_W'(1)};
         m1_cfg_ff     <= '{shape: SHAPE_OFF, peak: '0, len_a: LEN_W'(1), len_b: LEN_W'(1)};
         vin_ff        <= 1'b0;
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         m0_cfg_ff <= m0_cfg_in;
         m1_cfg_ff <= m1_cfg_in;
         if (adv) begin
            vin_ff        <= req_tvalid;
            vld_ff        <= {vld_ff[MODE_LAT-2:0], vin_ff};
            rsp_tvalid_ff <= vld_ff[MODE_LAT-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff     <= req_tdata[HEIGHT_W-1:0];
         total_ff <= total_in;
      end
   end

   // ---------------------------------------------------------------- mode lanes
   dps_mode #(.FACTOR_BITS(FACTOR_BITS)) u_mode0 (
      .clock   (clock),
      .en      (adv),
      .cfg     (m0_cfg_ff),
      .height  (h_ff),
      .density (dens0)
   );

   dps_mode #(.FACTOR_BITS(FACTOR_BITS)) u_mode1 (
      .clock   (clock),
      .en      (adv),
      .cfg     (m1_cfg_ff),
      .height  (h_ff),
      .density (dens1)
   );

   assign total_in   = TOTAL_W'(dens0) + TOTAL_W'(dens1);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-TOTAL_W){1'b0}}, total_ff};

   // ---------------------------------------------------------------- checks
   // a held pipeline keeps every item where it is
   a_hold_valids: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (vld_ff == $past(vld_ff)) && (vin_ff == $past(vin_ff)))
      else $error("valid chain moved during stall");

   // an accepted item enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vin_ff)
      else $error("accepted item not captured");

   // a result appears only from the last lane stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(vld_ff[MODE_LAT-1]))
      else $error("result without item in last stage");

endmodule
